FILE: hw/rtl/igfb_pkg.sv
package igfb_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int QUEUE_DEPTH = 16;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // input item queue between front and back
    localparam int IQ_DEPTH = 2;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FLEN_W   = 12;
    localparam int CNT_W    = 16;
    localparam int GAP_W    = 16;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(10);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    localparam logic [MODE_W-1:0] MODE_BYTE  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_TICK  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(3);

    typedef logic [RING_AW-1:0]  t_ridx;
    typedef logic [QUEUE_AW-1:0] t_qidx;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_TICK,
        KIND_READ,
        KIND_CLEAR
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_TICK    = 3'd2,
        ST_QUEUED  = 3'd3,
        ST_LOST    = 3'd4,
        ST_READ    = 3'd5,
        ST_EMPTY   = 3'd6,
        ST_CLEARED = 3'd7
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  byte_value;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic               last;
        logic [FLEN_W-1:0]  flen;
        logic [CNT_W-1:0]   fseen;
    } t_res;

    // (a + b) modulo RING_DEPTH, both operands below RING_DEPTH
    function automatic t_ridx ring_add(input t_ridx a, input t_ridx b);
        logic [RING_AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (RING_AW + 1)'(RING_DEPTH)) begin
            s = s - (RING_AW + 1)'(RING_DEPTH);
        end
        return s[RING_AW-1:0];
    endfunction

    // (a - b) modulo RING_DEPTH
    function automatic t_ridx ring_sub(input t_ridx a, input t_ridx b);
        t_ridx d;
        d = a - b;
        if (a < b) begin
            d = d + RING_AW'(RING_DEPTH);
        end
        return d;
    endfunction

    function automatic t_qidx queue_inc(input t_qidx a);
        return (a == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : a + QUEUE_AW'(1);
    endfunction

endpackage

FILE: hw/rtl/igfb_in_if.sv
interface igfb_in_if import igfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [BYTE_W-1:0]  byte_value;

    modport source (output valid, output mode, output byte_value, input ready);
    modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

FILE: hw/rtl/igfb_out_if.sv
interface igfb_out_if import igfb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last_byte;
    logic [FLEN_W-1:0]    frame_length;
    logic [CNT_W-1:0]     frames_seen;

    modport source (output valid, output status, output data_byte, output last_byte,
                    output frame_length, output frames_seen, input ready);
    modport sink   (input valid, input status, input data_byte, input last_byte,
                    input frame_length, input frames_seen, output ready);
endinterface

FILE: hw/rtl/igfb_ram.sv
module igfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/igfb_front.sv
module igfb_front import igfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    igfb_in_if.sink     i_item,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_ready
);
    t_item              r_buf [IQ_DEPTH];
    logic [IQ_AW-1:0]   r_wptr, n_wptr;
    logic [IQ_AW-1:0]   r_rptr, n_rptr;
    logic [IQ_CW-1:0]   r_count, n_count;
    t_item              w_cls;
    logic               w_push;
    logic               w_pop;

    // classify the mode into an operation kind
    always_comb begin
        w_cls.byte_value = i_item.byte_value;
        case (i_item.mode)
            MODE_BYTE:  w_cls.kind = KIND_BYTE;
            MODE_TICK:  w_cls.kind = KIND_TICK;
            MODE_READ:  w_cls.kind = KIND_READ;
            MODE_CLEAR: w_cls.kind = KIND_CLEAR;
            default:    w_cls.kind = KIND_CLEAR;
        endcase
    end

    assign i_item.ready = (r_count != IQ_CW'(IQ_DEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign o_valid      = (r_count != '0);
    assign o_item       = r_buf[r_rptr];
    assign w_pop        = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == IQ_AW'(IQ_DEPTH - 1)) ? '0 : r_wptr + IQ_AW'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == IQ_AW'(IQ_DEPTH - 1)) ? '0 : r_rptr + IQ_AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + IQ_CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - IQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (w_push) begin
            r_buf[r_wptr] <= w_cls;
        end
    end
endmodule

FILE: hw/rtl/igfb_back.sv
module igfb_back import igfb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GAP_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_ready,
    igfb_out_if.source        o_result
);
    // framer state
    t_ridx              r_wr_idx, n_wr_idx;
    t_ridx              r_rd_idx, n_rd_idx;
    t_ridx              r_fstart, n_fstart;
    t_ridx              r_off, n_off;
    t_qidx              r_head, n_head;
    t_qidx              r_tail, n_tail;
    logic [GAP_W-1:0]   r_idle, n_idle;
    logic [CNT_W-1:0]   r_fcnt, n_fcnt;
    logic [GAP_W-1:0]   r_gap;
    t_ridx              r_dstart [QUEUE_DEPTH];
    t_ridx              r_dlen   [QUEUE_DEPTH];

    // in-flight stage (ring read pending) and output register
    logic               r_p_valid, n_p_valid;
    t_res               r_p_res;
    logic               r_o_valid, n_o_valid;
    t_res               r_o_res;
    logic [BYTE_W-1:0]  r_o_data;

    t_res               w_res;
    logic               w_fire;
    logic               w_oload;
    logic               w_desc_we;
    logic               w_ram_we;
    logic               w_ram_re;
    t_ridx              w_raddr;
    t_ridx              w_len;
    t_ridx              w_st;
    t_ridx              w_dl;
    logic [BYTE_W-1:0]  w_rdata;

    assign w_oload = !r_o_valid || o_result.ready;
    assign o_ready = !r_p_valid || w_oload;
    assign w_fire  = i_valid && o_ready;
    assign w_st    = r_dstart[r_head];
    assign w_dl    = r_dlen[r_head];
    assign w_len   = ring_sub(r_wr_idx, r_fstart);

    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_fstart  = r_fstart;
        n_off     = r_off;
        n_head    = r_head;
        n_tail    = r_tail;
        n_idle    = r_idle;
        n_fcnt    = r_fcnt;
        w_desc_we = 1'b0;
        w_ram_we  = 1'b0;
        w_ram_re  = 1'b0;
        w_raddr   = ring_add(w_st, r_off);
        w_res     = '{status: ST_CLEARED, last: 1'b0, flen: '0, fseen: '0};
        case (i_item.kind)
            KIND_BYTE: begin
                // store only while two or more slots are free
                if (ring_sub(r_rd_idx, r_wr_idx) != RING_AW'(1)) begin
                    w_ram_we     = w_fire;
                    n_wr_idx     = ring_add(r_wr_idx, RING_AW'(1));
                    n_idle       = '0;
                    w_res.status = ST_STORED;
                end else begin
                    w_res.status = ST_DROPPED;
                end
            end
            KIND_TICK: begin
                if (r_idle != '1) begin
                    n_idle = r_idle + GAP_W'(1);
                end
                w_res.status = ST_TICK;
                if (n_idle >= r_gap && r_fstart != r_wr_idx) begin
                    if (queue_inc(r_tail) == r_head) begin
                        w_res.status = ST_LOST;
                    end else begin
                        w_desc_we    = w_fire;
                        n_tail       = queue_inc(r_tail);
                        w_res.status = ST_QUEUED;
                    end
                    w_res.flen = FLEN_W'(w_len);
                    n_fstart   = r_wr_idx;
                    if (r_fcnt != CNT_MAX) begin
                        n_fcnt = r_fcnt + CNT_W'(1);
                    end
                end
            end
            KIND_READ: begin
                if (r_head == r_tail) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_ram_re     = w_fire;
                    w_res.status = ST_READ;
                    w_res.flen   = FLEN_W'(w_dl);
                    n_off        = r_off + RING_AW'(1);
                    if (({1'b0, r_off} + (RING_AW + 1)'(1)) >= {1'b0, w_dl}) begin
                        w_res.last = 1'b1;
                        n_rd_idx   = ring_add(w_st, w_dl);
                        n_head     = queue_inc(r_head);
                        n_off      = '0;
                    end
                end
            end
            KIND_CLEAR: begin
                n_wr_idx     = '0;
                n_rd_idx     = '0;
                n_fstart     = '0;
                n_off        = '0;
                n_head       = '0;
                n_tail       = '0;
                n_idle       = '0;
                n_fcnt       = '0;
                w_res.status = ST_CLEARED;
            end
            default: begin
                w_res.status = ST_CLEARED;
            end
        endcase
        w_res.fseen = n_fcnt;
    end

    always_comb begin
        n_p_valid = w_fire ? 1'b1 : (w_oload ? 1'b0 : r_p_valid);
        n_o_valid = w_oload ? r_p_valid : r_o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_fstart  <= '0;
            r_off     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_idle    <= '0;
            r_fcnt    <= '0;
            r_gap     <= GAP_RESET;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_wr_idx <= n_wr_idx;
                r_rd_idx <= n_rd_idx;
                r_fstart <= n_fstart;
                r_off    <= n_off;
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_idle   <= n_idle;
                r_fcnt   <= n_fcnt;
            end
            if (i_cfg_we) begin
                r_gap <= i_cfg_wdata;
            end
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
        if (w_desc_we) begin
            r_dstart[r_tail] <= r_fstart;
            r_dlen[r_tail]   <= w_len;
        end
        if (w_fire) begin
            r_p_res <= w_res;
        end
        // take the ring data while it still belongs to the in-flight item
        if (w_oload && r_p_valid) begin
            r_o_res  <= r_p_res;
            r_o_data <= (r_p_res.status == ST_READ) ? w_rdata : '0;
        end
    end

    igfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_item.byte_value),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_result.valid        = r_o_valid;
    assign o_result.status       = r_o_res.status;
    assign o_result.data_byte    = r_o_data;
    assign o_result.last_byte    = r_o_res.last;
    assign o_result.frame_length = r_o_res.flen;
    assign o_result.frames_seen  = r_o_res.fseen;
endmodule

FILE: hw/rtl/idle_gap_frame_buffer_top.sv
// An item passes the item queue, in-flight stage and output register.
// Throughput: one item per cycle while results are taken; the back
//   executes it with at most one ring write or registered ring read.
// Reset (synchronous, i_rst_n low): empty ring, descriptor queue and item
//   queue, zero counters, gap_ticks back to 10; ring and descriptor
//   contents are left as they are.
module idle_gap_frame_buffer_top import igfb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GAP_W-1:0]  i_cfg_wdata,
    igfb_in_if.sink           i_item,
    igfb_out_if.source        o_result
);
    // front to back: classified item with its handshake
    logic   w_valid;
    t_item  w_item;
    logic   w_ready;

    // Front: accept items into a short queue and decode the mode, so the
    // input side keeps moving while the back waits on the result side.
    igfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (w_valid),
        .o_item  (w_item),
        .i_ready (w_ready)
    );

    // Back: update ring indices, idle count and descriptor queue, access
    // the ring memory, and hold each result in an output register until
    // it is taken.
    igfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_ready     (w_ready),
        .o_result    (o_result)
    );
endmodule

FILE: hw/rtl/igfb_checker.sv
module igfb_checker import igfb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [STATUS_W-1:0]  i_status,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_last_byte,
    input  logic [FLEN_W-1:0]    i_frame_length,
    input  logic [CNT_W-1:0]     i_frames_seen
);
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_data_byte) && $stable(i_frame_length))
        else $error("stalled result changed");

    a_data_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_READ |-> i_data_byte == '0 && !i_last_byte)
        else $error("data or last mark outside a byte read");

    a_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_STORED || i_status == ST_DROPPED
            || i_status == ST_TICK || i_status == ST_EMPTY
            || i_status == ST_CLEARED) |-> i_frame_length == '0)
        else $error("frame length given without a frame");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_CLEARED |-> i_frames_seen == '0)
        else $error("frame count not zero after clear");
endmodule

bind idle_gap_frame_buffer_top igfb_checker u_igfb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_status       (o_result.status),
    .i_data_byte    (o_result.data_byte),
    .i_last_byte    (o_result.last_byte),
    .i_frame_length (o_result.frame_length),
    .i_frames_seen  (o_result.frames_seen)
);
